@@ rtl/ipf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ipf_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ORDER      = 3'd0,
    CFG_LEADING    = 3'd1,
    CFG_INVERSE    = 3'd2,
    CFG_TWO_THIRDS = 3'd3,
    CFG_ONE_THIRD  = 3'd4,
    CFG_OFFSET     = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int FREQ_W     = 32;
  localparam int PHASE_W    = 48;

  // root path: y in Q0.30, x in Q.24 up to 2^32
  localparam int Y_W   = 31;
  localparam int ACC_W = 34;
  localparam int X_W   = 33;
  localparam logic [Y_W-1:0]   ONE30    = 31'h4000_0000;
  localparam logic [ACC_W-1:0] FOUR30   = 34'h1_0000_0000;
  // ceil(2^35 / 3), exact floor division by three for values below 2^33
  localparam logic [ACC_W-1:0] DIV3_MUL = 34'h2_AAAA_AAAB;

  // series lanes: leading x^5, inverse x^3, two-thirds x^2, one-third x
  localparam int LANES      = 4;
  localparam int MAX_ROUNDS = 5;
  localparam int MAG_W      = 96;
  localparam int PP_W       = 65;
  localparam int TERM_W     = 98;
  localparam int SUM_W      = 100;
  localparam int LANE_ROUNDS [LANES] = '{5, 3, 2, 1};
  // lane is subtracted from the sum
  localparam logic [LANES-1:0] LANE_SUB = 4'b1011;

  localparam logic signed [PHASE_W-1:0] PHASE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [PHASE_W-1:0] PHASE_MIN = 48'sh8000_0000_0000;

  // register file contents
  typedef struct packed {
    logic [2:0]                  order;
    logic signed [PHASE_W-1:0]   lead;
    logic signed [PHASE_W-1:0]   inv;
    logic signed [PHASE_W-1:0]   two;
    logic signed [PHASE_W-1:0]   one;
    logic signed [PHASE_W-1:0]   offset;
  } ipf_coef_t;

  // normalised frequency with seed
  typedef struct packed {
    logic [FREQ_W-1:0] mn;
    logic [1:0]        rem;
    logic [3:0]        pdiv;
    logic              zero;
    logic [Y_W-1:0]    y;
  } ipf_norm_t;

  // root result
  typedef struct packed {
    logic [X_W-1:0] x;
    logic           zero;
  } ipf_root_t;

  // seed table entry: largest Q0.16 y with y^3 * u_mid <= 1
  function automatic logic [16:0] seed_entry(int r, int i, int idx_w);
    logic [63:0] m12;
    logic [63:0] u12;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] c;
    m12 = 64'd4096 + ((64'(2 * i + 1) << 12) >> (idx_w + 1));
    u12 = m12 << r;
    lo  = 64'd0;
    hi  = 64'd65536;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      c   = mid * mid * mid;
      if (c * u12 <= (64'd1 << 60)) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo[16:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/ipf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// frequency samples in
interface ipf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] freq;
  modport source (output valid, output freq, input ready);
  modport sink   (input valid, input freq, output ready);
endinterface

// phase results out
interface ipf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] phase;
  logic               bad_freq;
  logic               saturated;
  modport source (output valid, output phase, output bad_freq, output saturated,
                  input ready);
  modport sink   (input valid, input phase, input bad_freq, input saturated,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/inspiral_phase_from_frequency_core.sv @@
// Inspiral phase from normalised frequency, series up to second order.
// Input channel in_ch carries freq (unsigned Q8.24); each transfer gives
// exactly one transfer on out_ch with phase (signed Q24.24), bad_freq and
// saturated. Both channels are valid/ready; a transfer happens on a rising
// edge with both high.
// The cfg port writes one register per cycle with cfg_we high: index 0 series
// order, 1..4 coefficients, 5 phase offset. Write only while idle.
// Throughput: one item per cycle while out_ch.ready is high. The depth of the
// pipeline is set by the seed table read, five stages per Newton step and
// two stages per multiply-and-round of the longest (x^5) term chain.
// Every stage carries its own valid bit and loads whenever its successor can
// take data, so a stalled receiver holds the finished result in the output
// register while upstream bubbles still close up and new items are taken.
// Reset (synchronous, rst_n low) empties the pipeline and sets the order to
// four and all coefficients and the offset to zero. The seed table is a
// constant ROM, so no warm-up pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module inspiral_phase_from_frequency_core #(
  parameter int ROOT_SEED_DEPTH = 256,
  parameter int NEWTON_STEPS    = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ipf_in_if.sink                              in_ch,
  ipf_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ipf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ipf_pkg::*;

  ipf_coef_t coef_r;
  ipf_norm_t norm;
  ipf_root_t root;
  logic      seed_valid, seed_ready;
  logic      root_valid, root_ready;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.order  <= 3'd4;
      coef_r.lead   <= '0;
      coef_r.inv    <= '0;
      coef_r.two    <= '0;
      coef_r.one    <= '0;
      coef_r.offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORDER:      coef_r.order  <= cfg_data[2:0];
        CFG_LEADING:    coef_r.lead   <= cfg_data;
        CFG_INVERSE:    coef_r.inv    <= cfg_data;
        CFG_TWO_THIRDS: coef_r.two    <= cfg_data;
        CFG_ONE_THIRD:  coef_r.one    <= cfg_data;
        CFG_OFFSET:     coef_r.offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // normalise and seed
  ipf_seed #(
    .ROOT_SEED_DEPTH (ROOT_SEED_DEPTH)
  ) u_seed (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_freq   (in_ch.freq),
    .out_valid (seed_valid),
    .out_ready (seed_ready),
    .out_norm  (norm)
  );

  // inverse cube root refinement
  ipf_newton #(
    .NEWTON_STEPS (NEWTON_STEPS)
  ) u_newton (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seed_valid),
    .in_ready  (seed_ready),
    .in_norm   (norm),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_root  (root)
  );

  // term chains and saturating sum
  ipf_series u_series (
    .clk           (clk),
    .rst_n         (rst_n),
    .coef          (coef_r),
    .in_valid      (root_valid),
    .in_ready      (root_ready),
    .in_root       (root),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_phase     (out_ch.phase),
    .out_bad_freq  (out_ch.bad_freq),
    .out_saturated (out_ch.saturated)
  );

  // zero frequency gives a clean zero result
  a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bad_freq |-> out_ch.phase == '0 && !out_ch.saturated)
    else $error("bad_freq result not zero");

  // a clamped phase sits on a rail
  a_sat_rail : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      out_ch.phase == PHASE_MAX || out_ch.phase == PHASE_MIN)
    else $error("saturated phase off the rails");

  // reset empties the pipeline
  a_rst_empty : assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

@@ rtl/ipf_seed.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipf_seed #(
  parameter int ROOT_SEED_DEPTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          in_freq,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ipf_pkg::ipf_norm_t        out_norm
);
  import ipf_pkg::*;

  localparam int IDX_W  = $clog2(ROOT_SEED_DEPTH);
  localparam int ROM_AW = IDX_W + 2;

  typedef logic [16:0] rom_t [3*ROOT_SEED_DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < ROOT_SEED_DEPTH; i++) begin
        t[r*ROOT_SEED_DEPTH+i] = seed_entry(r, i, IDX_W);
      end
    end
    return t;
  endfunction

  localparam rom_t SEED_ROM = build_rom();

  logic [1:0]        v_r;
  logic [2:0]        rdy;
  logic [FREQ_W-1:0] mn_nxt, mn_r;
  logic [1:0]        rem_nxt, rem_r;
  logic [3:0]        pdiv_nxt, pdiv_r;
  logic [4:0]        p;
  logic [IDX_W-1:0]  idx_r;
  logic              zero_r;
  ipf_norm_t         norm_r;

  // stage advance chain
  assign rdy[2]   = out_ready;
  assign rdy[1]   = ~v_r[1] | rdy[2];
  assign rdy[0]   = ~v_r[0] | rdy[1];
  assign in_ready = rdy[0];

  // leading one position, split into p mod 3 and p div 3
  always_comb begin
    p        = '0;
    rem_nxt  = '0;
    pdiv_nxt = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (in_freq[i]) begin
        p        = 5'(i);
        rem_nxt  = 2'(i % 3);
        pdiv_nxt = 4'(i / 3);
      end
    end
    mn_nxt = in_freq << (~p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
    end
  end

  // normalise
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mn_r   <= mn_nxt;
      rem_r  <= rem_nxt;
      pdiv_r <= pdiv_nxt;
      idx_r  <= mn_nxt[30 -: IDX_W];
      zero_r <= (in_freq == '0);
    end
  end

  // seed table read
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      norm_r.mn   <= mn_r;
      norm_r.rem  <= rem_r;
      norm_r.pdiv <= pdiv_r;
      norm_r.zero <= zero_r;
      norm_r.y    <= {SEED_ROM[ROM_AW'({rem_r, idx_r})], 14'b0};
    end
  end

  assign out_valid = v_r[1];
  assign out_norm  = norm_r;

endmodule

`default_nettype wire

@@ rtl/ipf_newton.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipf_newton #(
  parameter int NEWTON_STEPS = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  ipf_pkg::ipf_norm_t in_norm,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ipf_pkg::ipf_root_t out_root
);
  import ipf_pkg::*;

  // five stages per step, one for the final scaling
  localparam int NS = 5 * NEWTON_STEPS + 1;

  typedef struct packed {
    logic [Y_W-1:0]    y;
    logic [ACC_W-1:0]  acc;
    logic [FREQ_W-1:0] mn;
    logic [1:0]        rem;
    logic [3:0]        pdiv;
    logic              zero;
  } nwt_t;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  nwt_t          st_r   [NS];
  nwt_t          st_w   [NS+1];
  nwt_t          st_nxt [NS];

  assign rdy[NS]   = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  always_comb begin
    st_w[0].y    = in_norm.y;
    st_w[0].acc  = '0;
    st_w[0].mn   = in_norm.mn;
    st_w[0].rem  = in_norm.rem;
    st_w[0].pdiv = in_norm.pdiv;
    st_w[0].zero = in_norm.zero;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    assign st_w[s+1] = st_r[s];
    assign rdy[s]    = ~v_r[s] | rdy[s+1];

    if (s == NS - 1) begin : g_scale
      // x = y * 2^(2 - p div 3), rounding half up on right shifts
      logic [Y_W:0] sum;
      logic [3:0]   sh;
      always_comb begin
        st_nxt[s] = st_w[s];
        sh        = st_w[s].pdiv - 4'd2;
        sum       = {1'b0, st_w[s].y} + ((Y_W+1)'(1) << (sh - 4'd1));
        if (st_w[s].pdiv > 4'd2) begin
          st_nxt[s].acc = ACC_W'(sum >> sh);
        end else begin
          st_nxt[s].acc = ACC_W'({3'b0, st_w[s].y} << (4'd2 - st_w[s].pdiv));
        end
      end
    end else if (s % 5 == 0) begin : g_sq
      // y^2
      logic [2*Y_W-1:0] prod;
      always_comb begin
        st_nxt[s]     = st_w[s];
        prod          = st_w[s].y * st_w[s].y;
        st_nxt[s].acc = {3'b0, prod[60:30]};
      end
    end else if (s % 5 == 1) begin : g_cube
      // y^3
      logic [2*Y_W-1:0] prod;
      always_comb begin
        st_nxt[s]     = st_w[s];
        prod          = st_w[s].acc[Y_W-1:0] * st_w[s].y;
        st_nxt[s].acc = {3'b0, prod[60:30]};
      end
    end else if (s % 5 == 2) begin : g_mant
      // t = m * y^3 scaled back by the residue
      logic [FREQ_W+Y_W-1:0] prod;
      always_comb begin
        st_nxt[s]     = st_w[s];
        prod          = st_w[s].mn * st_w[s].acc[Y_W-1:0];
        st_nxt[s].acc = {2'b0, prod[62:31]} << st_w[s].rem;
      end
    end else if (s % 5 == 3) begin : g_corr
      // y * max(0, 4 - t)
      logic [X_W-1:0] w;
      logic [63:0]    prod;
      always_comb begin
        st_nxt[s] = st_w[s];
        w         = (st_w[s].acc >= FOUR30) ? '0 : X_W'(FOUR30 - st_w[s].acc);
        prod      = st_w[s].y * w;
        st_nxt[s].acc = prod[63:30];
      end
    end else begin : g_div3
      // divide by three, clamp to one
      logic [2*ACC_W-1:0] prod;
      logic [32:0]        q;
      always_comb begin
        st_nxt[s] = st_w[s];
        prod      = st_w[s].acc * DIV3_MUL;
        q         = prod[67:35];
        st_nxt[s].y = (q > {2'b0, ONE30}) ? ONE30 : q[Y_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= (s == 0) ? in_valid : v_r[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_root.x    = st_r[NS-1].acc[X_W-1:0];
  assign out_root.zero = st_r[NS-1].zero;

endmodule

`default_nettype wire

@@ rtl/ipf_series.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipf_series (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  ipf_pkg::ipf_coef_t       coef,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  ipf_pkg::ipf_root_t       in_root,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [47:0]       out_phase,
  output logic                     out_bad_freq,
  output logic                     out_saturated
);
  import ipf_pkg::*;

  // load, two stages per round, signed terms, pair sums, output
  localparam int NS   = 2 * MAX_ROUNDS + 4;
  localparam int S_SG = 2 * MAX_ROUNDS + 1;
  localparam int S_PR = S_SG + 1;
  localparam int S_OUT = S_PR + 1;

  logic [NS-1:0]            v_r;
  logic [NS:0]              rdy;
  logic [NS-1:0]            v_nxt;
  logic [MAG_W-1:0]         mag_r  [MAX_ROUNDS+1][LANES];
  logic [PP_W-1:0]          pp_r   [MAX_ROUNDS][LANES][3];
  logic [X_W-1:0]           x_r    [2*MAX_ROUNDS-1];
  logic [LANES-1:0]         neg_r  [2*MAX_ROUNDS+1];
  logic [NS-2:0]            zero_r;
  logic signed [TERM_W-1:0] term_r [LANES];
  logic signed [SUM_W-1:0]  pa_r, pb_r;
  logic signed [SUM_W-1:0]  tot;
  logic signed [PHASE_W-1:0] coef_w [LANES];
  logic [LANES-1:0]         lane_on;
  logic signed [PHASE_W-1:0] phase_r;
  logic                     bad_r, sat_r;

  // stage advance chain
  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];
  assign v_nxt    = {v_r[NS-2:0], in_valid};

  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = ~v_r[s] | rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) v_r[s] <= v_nxt[s];
      end
    end
  end

  // lane coefficients, gated by the order register
  always_comb begin
    coef_w[0]  = coef.lead;
    coef_w[1]  = coef.inv;
    coef_w[2]  = coef.two;
    coef_w[3]  = coef.one;
    lane_on[0] = 1'b1;
    lane_on[1] = (coef.order >= 3'd2);
    lane_on[2] = (coef.order >= 3'd3);
    lane_on[3] = (coef.order >= 3'd4);
  end

  // load magnitudes and term signs
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < LANES; l++) begin
        mag_r[0][l] <= lane_on[l] ?
          MAG_W'($unsigned(coef_w[l][PHASE_W-1] ? -coef_w[l] : coef_w[l])) : '0;
        neg_r[0][l] <= coef_w[l][PHASE_W-1] ^ LANE_SUB[l];
      end
      x_r[0]    <= in_root.x;
      zero_r[0] <= in_root.zero;
    end
  end

  // carried fields
  for (genvar s = 1; s < NS - 1; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rdy[s]) zero_r[s] <= zero_r[s-1];
    end
  end

  for (genvar s = 1; s < 2 * MAX_ROUNDS + 1; s++) begin : g_negc
    always_ff @(posedge clk) begin
      if (rdy[s]) neg_r[s] <= neg_r[s-1];
    end
  end

  for (genvar s = 1; s < 2 * MAX_ROUNDS - 1; s++) begin : g_xc
    always_ff @(posedge clk) begin
      if (rdy[s]) x_r[s] <= x_r[s-1];
    end
  end

  // rounds: partial products, then sum with rounding to Q.24
  for (genvar j = 0; j < MAX_ROUNDS; j++) begin : g_round
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [129:0] full;
      logic [129:0] rnd;

      always_ff @(posedge clk) begin
        if (rdy[2*j+1]) begin
          for (int c = 0; c < 3; c++) begin
            if (j < LANE_ROUNDS[l]) begin
              pp_r[j][l][c] <= mag_r[j][l][32*c +: 32] * x_r[2*j];
            end else begin
              pp_r[j][l][c] <= {33'b0, mag_r[j][l][32*c +: 32]};
            end
          end
        end
      end

      always_comb begin
        full = {65'b0, pp_r[j][l][0]} + {33'b0, pp_r[j][l][1], 32'b0}
             + {1'b0, pp_r[j][l][2], 64'b0};
        rnd  = full + 130'h80_0000;
      end

      always_ff @(posedge clk) begin
        if (rdy[2*j+2]) begin
          mag_r[j+1][l] <= (j < LANE_ROUNDS[l]) ? rnd[119:24] : full[MAG_W-1:0];
        end
      end
    end
  end

  // signed terms
  always_ff @(posedge clk) begin
    if (rdy[S_SG]) begin
      for (int l = 0; l < LANES; l++) begin
        term_r[l] <= neg_r[2*MAX_ROUNDS][l] ? -$signed({2'b0, mag_r[MAX_ROUNDS][l]})
                                            :  $signed({2'b0, mag_r[MAX_ROUNDS][l]});
      end
    end
  end

  // pair sums
  always_ff @(posedge clk) begin
    if (rdy[S_PR]) begin
      pa_r <= SUM_W'(term_r[0]) + SUM_W'(term_r[1]);
      pb_r <= SUM_W'(term_r[2]) + SUM_W'(term_r[3]) + SUM_W'(coef.offset);
    end
  end

  // total, saturate, zero frequency override
  assign tot = pa_r + pb_r;

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      bad_r <= zero_r[NS-2];
      if (zero_r[NS-2]) begin
        phase_r <= '0;
        sat_r   <= 1'b0;
      end else if (!tot[SUM_W-1] && (tot[SUM_W-2:PHASE_W-1] != '0)) begin
        phase_r <= PHASE_MAX;
        sat_r   <= 1'b1;
      end else if (tot[SUM_W-1] && (tot[SUM_W-2:PHASE_W-1] != '1)) begin
        phase_r <= PHASE_MIN;
        sat_r   <= 1'b1;
      end else begin
        phase_r <= tot[PHASE_W-1:0];
        sat_r   <= 1'b0;
      end
    end
  end

  assign out_valid     = v_r[NS-1];
  assign out_phase     = phase_r;
  assign out_bad_freq  = bad_r;
  assign out_saturated = sat_r;

endmodule

`default_nettype wire
